### hdl/fba_pkg.sv
// Shared constants, codes and beat types of the frame bitmap allocator.
// Depends on nothing; every other file of the block but fba_ram imports it.
`default_nettype none

package fba_pkg;

    // Bitmap geometry.
    localparam int FRAME_COUNT = 262144;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int WCNT_W      = $clog2(WORD_COUNT + 1);
    localparam int BIT_W       = $clog2(WORD_BITS);

    // Field widths fixed by the interface.
    localparam int FRAME_W = 18;
    localparam int LIMIT_W = 19;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLAIM   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY         = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_IGNORED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame_index;
    } t_in_beat;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic [STAT_W-1:0]  status;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // latch the input beat and its default result
        logic clear_step;  // write a zero word at the word counter and advance
        logic read_cur;    // read the word at the word counter
        logic read_next;   // read the following word and advance the counter
        logic write_word;  // write back the modified word
        logic res_upd;     // update the result from the word just read
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_imm;      // input beat needs no bitmap access
        logic is_alloc;    // item in hand is an allocate
        logic word_full;   // word just read has no free frame
        logic scan_last;   // word just read is the last one inside the limit
        logic clr_last;    // clearing pass is at its last word
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/fba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/fba_datapath.sv
// Datapath of the frame bitmap allocator: bitmap RAM, word counter, limit
// register, result and output registers. Depends on fba_pkg and fba_ram.
`default_nettype none

module fba_datapath
    import fba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire t_in_beat             i_in_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [LIMIT_W-1:0]   i_cfg_wdata,
    output t_out_beat                 o_out_data
);

    logic [LIMIT_W-1:0]   r_limit;
    logic [OP_W-1:0]      r_op;
    logic [FRAME_W-1:0]   r_idx;
    logic [WCNT_W-1:0]    r_word;
    logic [WCNT_W-1:0]    r_words;
    t_out_beat            r_res;
    t_out_beat            r_out;

    logic [31:0]          lim_clip;
    logic [WCNT_W-1:0]    words_now;
    logic                 idx_beyond;
    logic                 in_imm;
    t_out_beat            in_res;
    logic [WCNT_W-1:0]    word_inc;
    logic [WCNT_W-1:0]    in_word;

    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [BIT_W-1:0]     free_bit;
    logic [WORD_BITS-1:0] idx_mask;
    logic [WORD_BITS-1:0] free_mask;
    logic [WORD_BITS-1:0] new_word;
    logic                 busy;

    // Lowest clear bit of a word.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

    // Number of whole words that an allocate may search.
    assign lim_clip  = (32'(r_limit) > 32'(FRAME_COUNT)) ? 32'(FRAME_COUNT) : 32'(r_limit);
    assign words_now = WCNT_W'(lim_clip >> BIT_W);

    // Decode of the incoming beat: cases settled without touching the bitmap.
    assign idx_beyond = 32'(i_in_data.frame_index) >= 32'(FRAME_COUNT);

    always_comb begin
        in_imm  = 1'b0;
        in_res  = '{result_frame: i_in_data.frame_index, status: ST_DONE};
        in_word = WCNT_W'(i_in_data.frame_index >> BIT_W);
        case (i_in_data.op)
            OP_ALLOC: begin
                in_res  = '{result_frame: '0, status: ST_EXHAUSTED};
                in_word = '0;
                in_imm  = (words_now == '0);
            end
            OP_CLAIM: begin
                in_imm = idx_beyond;
            end
            OP_RELEASE: begin
                if (i_in_data.frame_index == '0) begin
                    in_res = '{result_frame: '0, status: ST_ZERO_IGNORED};
                    in_imm = 1'b1;
                end else begin
                    in_imm = idx_beyond;
                end
            end
            default: begin
                in_res = '{result_frame: '0, status: ST_DONE};
                in_imm = 1'b1;
            end
        endcase
    end

    // Word modification for all three operations.
    assign free_bit  = first_zero(ram_rdata);
    assign free_mask = WORD_BITS'(1) << free_bit;
    assign idx_mask  = WORD_BITS'(1) << r_idx[BIT_W-1:0];
    assign busy      = (ram_rdata & idx_mask) != '0;

    always_comb begin
        case (r_op)
            OP_ALLOC:   new_word = ram_rdata | free_mask;
            OP_CLAIM:   new_word = ram_rdata | idx_mask;
            OP_RELEASE: new_word = ram_rdata & ~idx_mask;
            default:    new_word = ram_rdata;
        endcase
    end

    // RAM port control.
    assign word_inc  = r_word + WCNT_W'(1);
    assign ram_we    = i_cmd.clear_step | i_cmd.write_word;
    assign ram_waddr = r_word[ADDR_W-1:0];
    assign ram_wdata = i_cmd.clear_step ? '0 : new_word;
    assign ram_re    = i_cmd.read_cur | i_cmd.read_next;
    assign ram_raddr = i_cmd.read_next ? word_inc[ADDR_W-1:0] : r_word[ADDR_W-1:0];

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Word counter: sweeps the RAM after reset, then addresses each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_cmd.accept) begin
            r_word <= in_word;
        end else if (i_cmd.clear_step || i_cmd.read_next) begin
            r_word <= word_inc;
        end
    end

    // Item registers and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_data.op;
            r_idx   <= i_in_data.frame_index;
            r_words <= words_now;
            r_res   <= in_res;
        end else if (i_cmd.res_upd) begin
            if (r_op == OP_ALLOC) begin
                r_res <= '{result_frame: FRAME_W'({r_word[ADDR_W-1:0], free_bit}),
                           status: ST_DONE};
            end else begin
                r_res <= '{result_frame: r_idx,
                           status: (r_op == OP_CLAIM && busy) ? ST_BUSY : ST_DONE};
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_data       = r_out;
    assign o_stat.is_imm    = in_imm;
    assign o_stat.is_alloc  = (r_op == OP_ALLOC);
    assign o_stat.word_full = (ram_rdata == '1);
    assign o_stat.scan_last = (word_inc == r_words);
    assign o_stat.clr_last  = (r_word == WCNT_W'(WORD_COUNT - 1));

`ifndef SYNTH
    // The RAM is never read and written at the same address in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap read and write collide");

    // An allocate write sets exactly one more bit than the word read.
    a_alloc_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write_word && r_op == OP_ALLOC)
        |-> ($countones(ram_wdata) == $countones(ram_rdata) + 1))
        else $error("allocate did not set a single frame");

    // The scan never reads past the searched words.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read_next |-> (word_inc < r_words))
        else $error("allocate scan ran past the limit");
`endif

endmodule

`default_nettype wire

### hdl/fba_ctrl.sv
// Controller of the frame bitmap allocator: state machine, input stall and
// output valid. Depends on fba_pkg.
`default_nettype none

module fba_ctrl
    import fba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_dp_cmd        o_cmd,
    input  wire t_dp_stat  i_stat
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_MODIFY = 7'b0001000,
        S_TEST   = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == S_IDLE) && i_in_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.is_imm ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_cur = 1'b1;
                n_state        = i_stat.is_alloc ? S_TEST : S_MODIFY;
            end
            S_MODIFY: begin
                o_cmd.write_word = 1'b1;
                o_cmd.res_upd    = 1'b1;
                n_state          = S_DONE;
            end
            S_TEST: begin
                if (!i_stat.word_full) begin
                    o_cmd.write_word = 1'b1;
                    o_cmd.res_upd    = 1'b1;
                    n_state          = S_DONE;
                end else if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.read_next = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and taken beats.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // A result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free)
        else $error("output register overwritten");

    // An accepted beat goes either straight to completion or to a bitmap read.
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ || r_state == S_DONE))
        else $error("accepted beat took a wrong path");

    // A new result only appears out of the completion state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output valid rose outside completion");
`endif

endmodule

`default_nettype wire

### hdl/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: controller and datapath.
// Depends on fba_pkg, fba_ctrl, fba_datapath and fba_ram.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_stall    i_in_data   (t_in_beat)
//   out      output     o_out_valid / i_out_stall  o_out_data  (t_out_beat)
//   cfg      input      i_cfg_we                   i_cfg_wdata (frame_limit)
//
// Claim and release go through one bitmap RAM read and one write-back
// between acceptance and result. Allocate reads bitmap words until a free
// bit is found (at most the limit in words), the single read port scanning
// one word per cycle, and writes back the word in which it found one.
// Beats settled without the bitmap (no-op, release of frame 0, index beyond
// the bitmap, empty limit) go from acceptance straight to completion.
// After reset a clearing pass writes every bitmap word to zero, during
// which o_in_stall stays high; configuration writes are taken as ever.
// A result waits in the output register under i_out_stall while the next beat
// is accepted and worked on; that beat completes once the register is free.
`default_nettype none

module frame_bitmap_allocator
    import fba_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_beat           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_beat               o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencing.
    fba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // Bitmap storage and arithmetic.
    fba_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
